/* rtl/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// sha256_pkg
// Command codes, initial hash values, round constants and the SHA-256
// bit functions of the hash engine; the checker shares the command codes.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic [1:0] MODE_ABSORB   = 2'd0;
  localparam logic [1:0] MODE_FINALIZE = 2'd1;
  localparam logic [1:0] MODE_RESTART  = 2'd2;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LEN_START = 6'd56;

  typedef logic [31:0] word_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* rtl/sha256_hash_engine.sv */
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 over a byte stream: absorb, finalize with padding, emit digest, restart.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid, in_ready  | mode, data_byte
//  out     | out_valid, out_ready| digest_word, word_index, last_word
//
//  An absorbed byte is shifted into the block; the byte that fills a block
//  starts the shared round unit, then a fold into the hash words. A first
//  finalize pushes the pad mark, the zero bytes, a gap with no byte and the
//  length bytes, with one or two block compressions; a later one only
//  re-emits. Both hand out one digest word per cycle via the output register.
//  Reset restores the initial hash; in_ready is low while padding, rounds or
//  digest words are in progress. out_ready low holds the current word.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MARK  = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_FOLD  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]  state;
  logic [2:0]  resume;
  logic [5:0]  count;
  logic [63:0] bits;
  logic        finalized;
  logic [5:0]  round;
  logic [2:0]  len_cnt;
  logic [63:0] len_sh;
  logic [2:0]  emit_idx;
  word_t       hash [8];
  word_t       st [8];
  word_t       blk [16];

  logic  push_en;
  logic  [7:0] push_byte;
  logic  out_load;
  word_t t1;
  word_t t2;
  word_t sched_next;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    case (state)
      S_IDLE: begin
        push_en   = in_valid && (mode == MODE_ABSORB) && !finalized;
        push_byte = data_byte;
      end
      S_MARK: begin
        push_en   = 1'b1;
        push_byte = PAD_MARK;
      end
      S_ZERO: begin
        push_en   = (count != LEN_START);
        push_byte = 8'h00;
      end
      S_LEN: begin
        push_en   = 1'b1;
        push_byte = len_sh[63:56];
      end
      default: begin
        push_en   = 1'b0;
        push_byte = 8'h00;
      end
    endcase
  end

  always_comb begin
    t1 = st[7] + big_sigma1(st[4]) + ((st[4] & st[5]) ^ (~st[4] & st[6]))
         + ROUND_K[round] + blk[0];
    t2 = big_sigma0(st[0]) + ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
    sched_next = small_sigma1(blk[14]) + blk[9] + small_sigma0(blk[1]) + blk[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      resume    <= S_IDLE;
      count     <= '0;
      bits      <= '0;
      finalized <= 1'b0;
      round     <= '0;
      len_cnt   <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      hash      <= INIT_HASH;
    end else begin
      if (out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (push_en) begin
        for (int j = 0; j < 15; j++) begin
          blk[j] <= {blk[j][23:0], blk[j+1][31:24]};
        end
        blk[15] <= {blk[15][23:0], push_byte};
        count   <= count + 6'd1;
        if (count == LAST_BYTE) begin
          st    <= hash;
          round <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (mode)
              MODE_ABSORB: begin
                if (!finalized) begin
                  bits <= bits + 64'd8;
                  if (count == LAST_BYTE) begin
                    state  <= S_ROUND;
                    resume <= S_IDLE;
                  end
                end
              end
              MODE_FINALIZE: begin
                emit_idx <= '0;
                if (finalized) begin
                  state <= S_EMIT;
                end else begin
                  len_sh <= bits;
                  state  <= S_MARK;
                end
              end
              MODE_RESTART: begin
                hash      <= INIT_HASH;
                count     <= '0;
                bits      <= '0;
                finalized <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_MARK: begin
          resume <= S_ZERO;
          state  <= (count == LAST_BYTE) ? S_ROUND : S_ZERO;
        end
        S_ZERO: begin
          if (count == LEN_START) begin
            len_cnt <= '0;
            state   <= S_LEN;
          end else if (count == LAST_BYTE) begin
            resume <= S_ZERO;
            state  <= S_ROUND;
          end
        end
        S_LEN: begin
          len_sh  <= {len_sh[55:0], 8'h00};
          len_cnt <= len_cnt + 3'd1;
          if (len_cnt == 3'd7) begin
            finalized <= 1'b1;
            resume    <= S_EMIT;
            state     <= S_ROUND;
          end
        end
        S_ROUND: begin
          st[0] <= t1 + t2;
          st[1] <= st[0];
          st[2] <= st[1];
          st[3] <= st[2];
          st[4] <= st[3] + t1;
          st[5] <= st[4];
          st[6] <= st[5];
          st[7] <= st[6];
          for (int j = 0; j < 15; j++) begin
            blk[j] <= blk[j+1];
          end
          blk[15] <= sched_next;
          round   <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          for (int j = 0; j < 8; j++) begin
            hash[j] <= hash[j] + st[j];
          end
          state <= resume;
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid   <= 1'b1;
            digest_word <= hash[emit_idx];
            word_index  <= emit_idx;
            last_word   <= (emit_idx == 3'd7);
            emit_idx    <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/sha256_checker.sv */
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the hash engine: output hold, last_word flag, digest
// word order, busy after finalize, restart completing at once.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);
  import sha256_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word)
      && $stable(word_index) && $stable(last_word))
    else $error("output item changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> out_valid
      && (word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_FINALIZE) |=> !in_ready)
    else $error("ready after finalize item");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_RESTART) |=> in_ready)
    else $error("busy after restart item");

endmodule

bind sha256_hash_engine sha256_checker u_sha256_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .mode        (mode),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last_word   (last_word)
);
